@@ design/qpe_pkg.sv @@
// types, character constants and the per-byte encoding function of the quoted-printable encoder
package qpe_pkg;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_QM  = 8'h3F;
    localparam logic [7:0] PRINT_LO = 8'd33;
    localparam logic [7:0] PRINT_HI = 8'd126;

    localparam int          COL_W         = 10;
    localparam logic [9:0]  LINE_LEN_RST  = 10'd76;
    localparam int          SEG_CHARS     = 6;
    localparam int          ITEM_CHARS    = 12;
    localparam logic [10:0] ROOM_LITERAL  = 11'd2;
    localparam logic [10:0] ROOM_HEX      = 11'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } qp_item_t;

    typedef struct packed {
        logic [SEG_CHARS-1:0][7:0] chars;
        logic [2:0]                cnt;
        logic [COL_W-1:0]          col;
    } enc_seg_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = 8'h30 + {4'd0, nib};
        end
        else
        begin
            d = 8'h37 + {4'd0, nib};
        end
        return d;
    endfunction

    function automatic enc_seg_t qpe_encode(
        input logic [7:0]       c,
        input logic             at_end,
        input logic [7:0]       nxt,
        input logic [COL_W-1:0] col,
        input logic [COL_W-1:0] line_len
    );
        enc_seg_t         s;
        logic             is_hex;
        logic             brk;
        logic [COL_W-1:0] base;
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic [7:0]       c2;
        s.chars = '0;
        s.cnt   = 3'd0;
        s.col   = col;
        is_hex  = 1'b0;
        case (c)
            CHAR_DOT: is_hex = (col == '0);
            CHAR_SP:  is_hex = at_end || (nxt == CHAR_LF) || (nxt == CHAR_CR);
            CHAR_TAB, CHAR_EQ, CHAR_QM: is_hex = 1'b1;
            default:  is_hex = !(c inside {[PRINT_LO:PRINT_HI]});
        endcase
        brk  = ({1'b0, col} + (is_hex ? ROOM_HEX : ROOM_LITERAL)) > {1'b0, line_len};
        base = brk ? '0 : col;
        if (is_hex)
        begin
            c0 = CHAR_EQ;
            c1 = hex_digit(c[7:4]);
            c2 = hex_digit(c[3:0]);
        end
        else
        begin
            c0 = c;
            c1 = 8'h00;
            c2 = 8'h00;
        end
        if (c == CHAR_CR)
        begin
            s.cnt = 3'd0;
        end
        else if (c == CHAR_LF)
        begin
            s.chars[0] = CHAR_CR;
            s.chars[1] = CHAR_LF;
            s.cnt      = 3'd2;
            s.col      = '0;
        end
        else if (brk)
        begin
            s.chars[0] = CHAR_EQ;
            s.chars[1] = CHAR_CR;
            s.chars[2] = CHAR_LF;
            s.chars[3] = c0;
            s.chars[4] = c1;
            s.chars[5] = c2;
            s.cnt      = is_hex ? 3'd6 : 3'd4;
            s.col      = base + (is_hex ? 10'd3 : 10'd1);
        end
        else
        begin
            s.chars[0] = c0;
            s.chars[1] = c1;
            s.chars[2] = c2;
            s.cnt      = is_hex ? 3'd3 : 3'd1;
            s.col      = base + (is_hex ? 10'd3 : 10'd1);
        end
        return s;
    endfunction

endpackage

@@ design/quoted_printable_encoder_top.sv @@
// quoted-printable encoder: input register, encode logic and output character shift buffer
//
// channel  | handshake           | payload
// ---------+---------------------+---------------------------
// msg      | msg_valid/msg_stall | msg_item  (in_byte, in_last)
// qp       | qp_valid/qp_stall   | qp_item   (out_char, out_last)
// cfg      | cfg_wr_en           | cfg_wr_data (line_length)
//
// one output character per cycle while qp_stall is low; an item causes 0 to 12 characters
// (literal 1, hex 3, soft break 3 more, lf 2) and passes through the input register
// the next item is encoded as the last character of the current one leaves the output buffer, or while it is empty
// reset clears the lookahead byte, the column and the valid flags of both buffers; line_length returns to 76
// a stall on qp holds the buffer; msg stalls only while the input register waits for it
module quoted_printable_encoder_top
    import qpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             msg_valid,
    output logic             msg_stall,
    input  msg_item_t        msg_item,
    output logic             qp_valid,
    input  logic             qp_stall,
    output qp_item_t         qp_item,
    input  logic             cfg_wr_en,
    input  logic [COL_W-1:0] cfg_wr_data
);

    logic [COL_W-1:0]               line_len_reg, line_len_next;
    logic                           in_valid_reg, in_valid_next;
    msg_item_t                      in_reg, in_next;
    logic [7:0]                     held_byte_reg, held_byte_next;
    logic                           held_valid_reg, held_valid_next;
    logic [COL_W-1:0]               column_reg, column_next;
    logic [ITEM_CHARS-1:0][7:0]     buf_reg, buf_next;
    logic [3:0]                     cnt_reg, cnt_next;

    enc_seg_t                       seg_a;
    enc_seg_t                       seg_b;
    logic [2:0]                     n_a;
    logic [2:0]                     n_b;
    logic [COL_W-1:0]               col_a;
    logic [ITEM_CHARS*8-1:0]        merged;
    logic                           emit;
    logic                           move;

    assign seg_a = qpe_encode(held_byte_reg, 1'b0, in_reg.in_byte, column_reg, line_len_reg);
    assign n_a   = held_valid_reg ? seg_a.cnt : 3'd0;
    assign col_a = held_valid_reg ? seg_a.col : column_reg;
    assign seg_b = qpe_encode(in_reg.in_byte, 1'b1, 8'h00, col_a, line_len_reg);
    assign n_b   = in_reg.in_last ? seg_b.cnt : 3'd0;

    always_comb
    begin
        logic [ITEM_CHARS*8-1:0] part_a;
        logic [ITEM_CHARS*8-1:0] part_b;
        part_a = held_valid_reg ? {48'd0, seg_a.chars} : '0;
        part_b = in_reg.in_last ? {48'd0, seg_b.chars} : '0;
        merged = part_a | (part_b << {n_a, 3'b000});
    end

    assign qp_valid         = (cnt_reg != 4'd0);
    assign qp_item.out_char = buf_reg[0];
    assign qp_item.out_last = (cnt_reg == 4'd1);
    assign emit             = qp_valid && !qp_stall;
    assign move             = in_valid_reg && (!qp_valid || (emit && qp_item.out_last));
    assign msg_stall        = in_valid_reg && !move;

    always_comb
    begin
        line_len_next   = cfg_wr_en ? cfg_wr_data : line_len_reg;
        in_valid_next   = in_valid_reg;
        in_next         = in_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        column_next     = column_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        if (emit)
        begin
            buf_next = {8'h00, buf_reg[ITEM_CHARS-1:1]};
            cnt_next = cnt_reg - 4'd1;
        end
        if (move)
        begin
            buf_next      = merged;
            cnt_next      = {1'b0, n_a} + {1'b0, n_b};
            in_valid_next = 1'b0;
            if (in_reg.in_last)
            begin
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                column_next     = '0;
            end
            else
            begin
                held_byte_next  = in_reg.in_byte;
                held_valid_next = 1'b1;
                column_next     = col_a;
            end
        end
        if (msg_valid && !msg_stall)
        begin
            in_valid_next = 1'b1;
            in_next       = msg_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= LINE_LEN_RST;
            in_valid_reg   <= 1'b0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            column_reg     <= '0;
            cnt_reg        <= 4'd0;
        end
        else
        begin
            line_len_reg   <= line_len_next;
            in_valid_reg   <= in_valid_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            column_reg     <= column_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        buf_reg <= buf_next;
    end

endmodule
